### src/dmt_pkg.sv
package dmt_pkg;

    // entry count, a power of two so the slot is the low bits of the hash
    localparam int ENTRIES   = 128;
    localparam int IDX_W     = $clog2(ENTRIES);
    localparam int PROC_BITS = 16;

    // beat field widths
    localparam int OPC_W      = 3;
    localparam int PID_W      = 16;
    localparam int ADDR_W     = 32;
    localparam int FLAG_W     = 12;
    localparam int CNT_W      = 32;
    localparam int PAGE_SHIFT = 12;
    localparam int VPAGE_W    = ADDR_W - PAGE_SHIFT;

    typedef enum logic [OPC_W-1:0] {
        OP_LOOKUP   = 3'd0,
        OP_FILL     = 3'd1,
        OP_INV_PROC = 3'd2,
        OP_INV_PAGE = 3'd3,
        OP_FLUSH    = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SWEEP
    } state_t;

    // one translation entry as held in the entry ram
    typedef struct packed {
        logic [PROC_BITS-1:0] proc;
        logic [VPAGE_W-1:0]   vpage;
        logic [VPAGE_W-1:0]   ppage;
        logic [FLAG_W-1:0]    perm;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

### src/dmt_ifs.sv
interface dmt_req_if;
    import dmt_pkg::*;

    logic                valid;
    logic                ready;
    logic [OPC_W-1:0]    opcode;
    logic [PID_W-1:0]    proc_id;
    logic [ADDR_W-1:0]   virt_addr;
    logic [ADDR_W-1:0]   phys_addr;
    logic [FLAG_W-1:0]   entry_flags;

    modport source (
        output valid, opcode, proc_id, virt_addr, phys_addr, entry_flags,
        input  ready
    );
    modport sink (
        input  valid, opcode, proc_id, virt_addr, phys_addr, entry_flags,
        output ready
    );
endinterface

interface dmt_rsp_if;
    import dmt_pkg::*;

    logic                valid;
    logic                ready;
    logic                hit;
    logic [ADDR_W-1:0]   translated_addr;
    logic [FLAG_W-1:0]   found_flags;
    logic [CNT_W-1:0]    hit_count;
    logic [CNT_W-1:0]    miss_count;

    modport source (
        output valid, hit, translated_addr, found_flags, hit_count, miss_count,
        input  ready
    );
    modport sink (
        input  valid, hit, translated_addr, found_flags, hit_count, miss_count,
        output ready
    );
endinterface

### src/dmt_ram.sv
module dmt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port (old data on collision)
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

### src/direct_mapped_tlb.sv
// request and ram read registered on accept; result beat registered in the execute state
// throughput: one request per cycle for lookup, fill, invalidate page and flush,
//   as long as the result side keeps draining; the entry ram is read on accept
// invalidate process reads every entry once through the single ram read port
//   and checks it against the process id
// reset is asynchronous: valid bits, counters and control clear at once, no clearing pass
module direct_mapped_tlb (
    input logic      clk,
    input logic      rst_n,
    dmt_req_if.sink  req,
    dmt_rsp_if.source rsp
);
    import dmt_pkg::*;

    // control state
    state_t                 state_reg, state_next;
    logic [ENTRIES-1:0]     valid_reg, valid_next;
    logic [CNT_W-1:0]       hits_reg, hits_next;
    logic [CNT_W-1:0]       misses_reg, misses_next;
    logic                   out_valid_reg, out_valid_next;
    logic [IDX_W:0]         sweep_cnt_reg, sweep_cnt_next;
    logic                   chk_valid_reg, chk_valid_next;
    logic                   fwd_hit_reg, fwd_hit_next;

    // payload state
    op_t                    op_reg, op_next;
    logic [PROC_BITS-1:0]   pid_reg, pid_next;
    logic [VPAGE_W-1:0]     vpage_reg, vpage_next;
    logic [PAGE_SHIFT-1:0]  offset_reg, offset_next;
    logic [VPAGE_W-1:0]     ppage_reg, ppage_next;
    logic [FLAG_W-1:0]      flags_reg, flags_next;
    logic [IDX_W-1:0]       slot_reg, slot_next;
    logic [IDX_W-1:0]       chk_idx_reg, chk_idx_next;
    entry_t                 fwd_data_reg, fwd_data_next;
    logic                   hit_reg, hit_next;
    logic [ADDR_W-1:0]      taddr_reg, taddr_next;
    logic [FLAG_W-1:0]      fflags_reg, fflags_next;
    logic [CNT_W-1:0]       hcnt_reg, hcnt_next;
    logic [CNT_W-1:0]       mcnt_reg, mcnt_next;

    // request decode
    op_t                    in_op;
    logic [PROC_BITS-1:0]   in_pid;
    logic [VPAGE_W-1:0]     in_vpage;
    logic [VPAGE_W-1:0]     in_hash;
    logic [IDX_W-1:0]       in_slot;
    logic                   out_free;
    logic                   exec_done;
    logic                   accept;
    logic                   sweep_rd;
    entry_t                 cur;
    entry_t                 fill_entry;
    logic                   match;

    // ram ports
    logic                   ram_we;
    logic                   ram_re;
    logic [IDX_W-1:0]       ram_raddr;
    logic [ENTRY_W-1:0]     ram_rdata;
    entry_t                 ram_entry;

    assign in_op    = op_t'(req.opcode);
    assign in_pid   = req.proc_id[PROC_BITS-1:0];
    assign in_vpage = req.virt_addr[ADDR_W-1:PAGE_SHIFT];
    assign in_hash  = VPAGE_W'(in_pid) ^ in_vpage;
    assign in_slot  = in_hash[IDX_W-1:0];

    // handshake
    assign out_free  = !out_valid_reg || rsp.ready;
    assign exec_done = (state_reg == ST_EXEC) && out_free;
    assign req.ready = (state_reg == ST_IDLE) || exec_done;
    assign accept    = req.valid && req.ready;

    // entry ram: looked up on accept, swept during invalidate process
    assign sweep_rd   = (state_reg == ST_SWEEP) && (sweep_cnt_reg < (IDX_W+1)'(ENTRIES));
    assign ram_re     = accept || sweep_rd;
    assign ram_raddr  = (state_reg == ST_SWEEP) ? sweep_cnt_reg[IDX_W-1:0] : in_slot;
    assign ram_we     = exec_done && (op_reg == OP_FILL);
    assign fill_entry = '{proc: pid_reg, vpage: vpage_reg, ppage: ppage_reg, perm: flags_reg};
    assign ram_entry  = entry_t'(ram_rdata);

    dmt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot_reg),
        .wdata (fill_entry),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // fill written back in the same cycle the next read of that slot was issued
    assign cur   = fwd_hit_reg ? fwd_data_reg : ram_entry;
    assign match = valid_reg[slot_reg] && (cur.proc == pid_reg) && (cur.vpage == vpage_reg);

    // next state and outputs
    always_comb
    begin
        state_next     = state_reg;
        valid_next     = valid_reg;
        hits_next      = hits_reg;
        misses_next    = misses_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        sweep_cnt_next = sweep_cnt_reg;
        chk_valid_next = chk_valid_reg;
        chk_idx_next   = chk_idx_reg;
        fwd_hit_next   = fwd_hit_reg;
        fwd_data_next  = fwd_data_reg;
        op_next        = op_reg;
        pid_next       = pid_reg;
        vpage_next     = vpage_reg;
        offset_next    = offset_reg;
        ppage_next     = ppage_reg;
        flags_next     = flags_reg;
        slot_next      = slot_reg;
        hit_next       = hit_reg;
        taddr_next     = taddr_reg;
        fflags_next    = fflags_reg;
        hcnt_next      = hcnt_reg;
        mcnt_next      = mcnt_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (in_op == OP_INV_PROC) ? ST_SWEEP : ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (out_free)
                begin
                    hit_next     = 1'b0;
                    taddr_next   = '0;
                    fflags_next  = '0;
                    fwd_hit_next = 1'b0;
                    unique case (op_reg)
                        OP_LOOKUP:
                        begin
                            if (match)
                            begin
                                hit_next    = 1'b1;
                                taddr_next  = {cur.ppage, offset_reg};
                                fflags_next = cur.perm;
                                hits_next   = hits_reg + CNT_W'(1);
                            end
                            else
                            begin
                                misses_next = misses_reg + CNT_W'(1);
                            end
                        end
                        OP_FILL:
                        begin
                            valid_next[slot_reg] = 1'b1;
                        end
                        OP_INV_PAGE:
                        begin
                            if (match)
                            begin
                                valid_next[slot_reg] = 1'b0;
                            end
                        end
                        OP_FLUSH:
                        begin
                            valid_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                    hcnt_next      = hits_next;
                    mcnt_next      = misses_next;
                    out_valid_next = 1'b1;
                    if (accept)
                    begin
                        state_next = (in_op == OP_INV_PROC) ? ST_SWEEP : ST_EXEC;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_SWEEP:
            begin
                // read entry n while checking entry n-1
                chk_valid_next = sweep_rd;
                chk_idx_next   = sweep_cnt_reg[IDX_W-1:0];
                if (sweep_rd)
                begin
                    sweep_cnt_next = sweep_cnt_reg + (IDX_W+1)'(1);
                end
                if (chk_valid_reg && valid_reg[chk_idx_reg] && (ram_entry.proc == pid_reg))
                begin
                    valid_next[chk_idx_reg] = 1'b0;
                end
                if (!sweep_rd && !chk_valid_reg)
                begin
                    sweep_cnt_next = '0;
                    state_next     = ST_EXEC;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // capture the request beat
        if (accept)
        begin
            op_next       = in_op;
            pid_next      = in_pid;
            vpage_next    = in_vpage;
            offset_next   = req.virt_addr[PAGE_SHIFT-1:0];
            ppage_next    = req.phys_addr[ADDR_W-1:PAGE_SHIFT];
            flags_next    = req.entry_flags;
            slot_next     = in_slot;
            fwd_hit_next  = (state_reg == ST_EXEC) && (op_reg == OP_FILL) &&
                            (in_slot == slot_reg) && (in_op != OP_INV_PROC);
            fwd_data_next = fill_entry;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            hits_reg      <= '0;
            misses_reg    <= '0;
            out_valid_reg <= 1'b0;
            sweep_cnt_reg <= '0;
            chk_valid_reg <= 1'b0;
            fwd_hit_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            hits_reg      <= hits_next;
            misses_reg    <= misses_next;
            out_valid_reg <= out_valid_next;
            sweep_cnt_reg <= sweep_cnt_next;
            chk_valid_reg <= chk_valid_next;
            fwd_hit_reg   <= fwd_hit_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        pid_reg      <= pid_next;
        vpage_reg    <= vpage_next;
        offset_reg   <= offset_next;
        ppage_reg    <= ppage_next;
        flags_reg    <= flags_next;
        slot_reg     <= slot_next;
        chk_idx_reg  <= chk_idx_next;
        fwd_data_reg <= fwd_data_next;
        hit_reg      <= hit_next;
        taddr_reg    <= taddr_next;
        fflags_reg   <= fflags_next;
        hcnt_reg     <= hcnt_next;
        mcnt_reg     <= mcnt_next;
    end

    // result beat
    assign rsp.valid           = out_valid_reg;
    assign rsp.hit             = hit_reg;
    assign rsp.translated_addr = taddr_reg;
    assign rsp.found_flags     = fflags_reg;
    assign rsp.hit_count       = hcnt_reg;
    assign rsp.miss_count      = mcnt_reg;

    // a result without a hit carries no translation
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !hit_reg |-> (taddr_reg == '0) && (fflags_reg == '0))
        else $error("non-hit result carries translation data");

    // every finished lookup bumps exactly one counter by one
    a_lookup_count: assert property (@(posedge clk) disable iff (!rst_n)
        exec_done && (op_reg == OP_LOOKUP) |=>
        CNT_W'(hits_reg + misses_reg) == CNT_W'($past(hits_reg + misses_reg) + CNT_W'(1)))
        else $error("lookup did not advance the counters by one");

    // a flush leaves no valid entry behind
    a_flush_clear: assert property (@(posedge clk) disable iff (!rst_n)
        exec_done && (op_reg == OP_FLUSH) |=> (valid_reg == '0))
        else $error("valid bits remain after flush");

    // forwarded fill data is only pending for an item in the execute cycle
    a_fwd_exec: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_hit_reg |-> (state_reg == ST_EXEC))
        else $error("forwarding flag set outside execute");
endmodule

### sim/translation_checker.sv
`timescale 1ns / 1ps

module translation_checker (
    input  logic clk,
    input  logic rst_n,
    dmt_req_if   req,
    dmt_rsp_if   rsp,
    output int   fails,
    output int   outstanding
);
    import dmt_pkg::*;

    localparam int SHOWN_MAX = 10;

    typedef struct packed {
        logic              hit;
        logic [ADDR_W-1:0] addr;
        logic [FLAG_W-1:0] flags;
        logic [CNT_W-1:0]  hits;
        logic [CNT_W-1:0]  misses;
    } xlate_result_t;

    // shadow copy of the translation entries and the two counters
    logic                 shadow_valid [ENTRIES];
    logic [PROC_BITS-1:0] shadow_proc  [ENTRIES];
    logic [VPAGE_W-1:0]   shadow_vpage [ENTRIES];
    logic [VPAGE_W-1:0]   shadow_ppage [ENTRIES];
    logic [FLAG_W-1:0]    shadow_perm  [ENTRIES];
    logic [CNT_W-1:0]     hits_seen;
    logic [CNT_W-1:0]     misses_seen;
    xlate_result_t        expected_results [$];
    int                   mismatches = 0;

    assign fails = mismatches;

    // apply one request beat to the shadow state, return the result it should give
    function automatic xlate_result_t translate(
        input logic [OPC_W-1:0]  opc,
        input logic [PID_W-1:0]  pid_in,
        input logic [ADDR_W-1:0] va,
        input logic [ADDR_W-1:0] pa,
        input logic [FLAG_W-1:0] flags
    );
        logic [PROC_BITS-1:0] pid;
        logic [VPAGE_W-1:0]   vpage;
        logic [VPAGE_W-1:0]   hash;
        int                   slot;
        xlate_result_t        res;
        pid   = pid_in[PROC_BITS-1:0];
        vpage = va[ADDR_W-1:PAGE_SHIFT];
        hash  = VPAGE_W'(pid) ^ vpage;
        slot  = int'(hash % ENTRIES);
        res   = '0;
        case (opc)
            OP_LOOKUP:
            begin
                if (shadow_valid[slot] && shadow_proc[slot] == pid
                    && shadow_vpage[slot] == vpage)
                begin
                    res.hit     = 1'b1;
                    res.addr    = {shadow_ppage[slot], va[PAGE_SHIFT-1:0]};
                    res.flags   = shadow_perm[slot];
                    hits_seen   = hits_seen + 1'b1;
                end
                else
                begin
                    misses_seen = misses_seen + 1'b1;
                end
            end
            OP_FILL:
            begin
                shadow_valid[slot] = 1'b1;
                shadow_proc[slot]  = pid;
                shadow_vpage[slot] = vpage;
                shadow_ppage[slot] = pa[ADDR_W-1:PAGE_SHIFT];
                shadow_perm[slot]  = flags;
            end
            OP_INV_PROC:
            begin
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (shadow_valid[i] && shadow_proc[i] == pid)
                        shadow_valid[i] = 1'b0;
                end
            end
            OP_INV_PAGE:
            begin
                if (shadow_valid[slot] && shadow_proc[slot] == pid
                    && shadow_vpage[slot] == vpage)
                    shadow_valid[slot] = 1'b0;
            end
            OP_FLUSH:
            begin
                for (int i = 0; i < ENTRIES; i++)
                    shadow_valid[i] = 1'b0;
            end
            // unused opcodes leave the state alone
            default:
            begin
            end
        endcase
        res.hits   = hits_seen;
        res.misses = misses_seen;
        return res;
    endfunction

    // predict on every request beat, compare every result beat in order
    always @(posedge clk or negedge rst_n)
    begin
        xlate_result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                shadow_valid[i] = 1'b0;
                shadow_proc[i]  = '0;
                shadow_vpage[i] = '0;
                shadow_ppage[i] = '0;
                shadow_perm[i]  = '0;
            end
            hits_seen   = '0;
            misses_seen = '0;
            expected_results.delete();
            outstanding <= 0;
        end
        else
        begin
            if (req.valid === 1'b1 && req.ready === 1'b1)
                expected_results.push_back(translate(req.opcode, req.proc_id,
                    req.virt_addr, req.phys_addr, req.entry_flags));
            if (rsp.valid === 1'b1 && rsp.ready === 1'b1)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= SHOWN_MAX)
                        $display("%0t: result beat with nothing expected", $time);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (rsp.hit !== want.hit || rsp.translated_addr !== want.addr
                        || rsp.found_flags !== want.flags || rsp.hit_count !== want.hits
                        || rsp.miss_count !== want.misses)
                    begin
                        mismatches++;
                        if (mismatches <= SHOWN_MAX)
                        begin
                            $display("%0t: expected hit=%0b addr=%08h flags=%03h hits=%0d misses=%0d",
                                $time, want.hit, want.addr, want.flags, want.hits, want.misses);
                            $display("%0t:      got hit=%0b addr=%08h flags=%03h hits=%0d misses=%0d",
                                $time, rsp.hit, rsp.translated_addr, rsp.found_flags,
                                rsp.hit_count, rsp.miss_count);
                        end
                    end
                end
            end
            outstanding <= expected_results.size();
        end
    end

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import dmt_pkg::*;

    localparam int    HALF_PERIOD   = 5;
    localparam int    RESET_CYCLES  = 12;
    localparam int    SETTLE_CYCLES = 10;
    localparam int    RANDOM_BEATS  = 1650;
    localparam int    PHASES        = 4;
    localparam int    MAP_DEPTH     = 24;
    localparam longint RUN_LIMIT_NS = 20_000_000;
    localparam logic [OPC_W-1:0] OPC_TOP = {OPC_W{1'b1}};

    typedef struct {
        logic [PID_W-1:0]  pid;
        logic [ADDR_W-1:0] va;
    } mapping_t;

    logic             clk = 1'b0;
    logic             rst_n;
    int               send_idle = 0;
    int               recv_stall = 0;
    int               fails;
    int               outstanding;
    mapping_t         known_maps [$];
    logic [PID_W-1:0] busy_pids [4];

    dmt_req_if req ();
    dmt_rsp_if rsp ();

    direct_mapped_tlb dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    translation_checker xlate_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .rsp         (rsp),
        .fails       (fails),
        .outstanding (outstanding)
    );

    always #HALF_PERIOD clk = ~clk;

    // run limit
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("FAILURE");
        $finish;
    end

    // result side: random stalls
    initial
    begin
        rsp.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            rsp.ready <= rst_n && ($urandom_range(99) >= recv_stall);
        end
    end

    // present one request beat and hold it until it is taken
    task automatic issue_request(
        input logic [OPC_W-1:0]  opc,
        input logic [PID_W-1:0]  pid,
        input logic [ADDR_W-1:0] va,
        input logic [ADDR_W-1:0] pa,
        input logic [FLAG_W-1:0] flags
    );
        while ($urandom_range(99) < send_idle)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid       <= 1'b1;
        req.opcode      <= opc;
        req.proc_id     <= pid;
        req.virt_addr   <= va;
        req.phys_addr   <= pa;
        req.entry_flags <= flags;
        @(posedge clk);
        while (req.ready !== 1'b1)
            @(posedge clk);
    endtask

    // stop sending until every expected result has come back
    task automatic wait_drained();
        req.valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    // stimulus and verdict
    initial
    begin
        int               pick;
        mapping_t         m;
        logic [PID_W-1:0] pid;
        logic [ADDR_W-1:0] va;
        logic [IDX_W-1:0] k;

        rst_n           = 1'b0;
        req.valid       = 1'b0;
        req.opcode      = OP_LOOKUP;
        req.proc_id     = '0;
        req.virt_addr   = '0;
        req.phys_addr   = '0;
        req.entry_flags = '0;
        busy_pids[0]    = '0;
        busy_pids[1]    = '1;
        busy_pids[2]    = PID_W'($urandom());
        busy_pids[3]    = PID_W'($urandom());
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: zero tag on an invalid entry, extremes, overwrite of slot 0
        issue_request(OP_LOOKUP, 16'h0000, 32'h0000_0000, 32'h0, 12'h0);
        issue_request(OP_FILL,   16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF);
        issue_request(OP_LOOKUP, 16'hFFFF, 32'hFFFF_FFFF, 32'h0, 12'h0);
        issue_request(OP_LOOKUP, 16'hFFFF, 32'hFFFF_F000, 32'h0, 12'h0);
        issue_request(OP_FILL,   16'h0000, 32'h0000_0000, 32'h0000_0FFF, 12'h000);
        issue_request(OP_LOOKUP, 16'h0000, 32'h0000_0ABC, 32'h0, 12'h0);
        issue_request(OP_LOOKUP, 16'hFFFF, 32'hFFFF_FFFF, 32'h0, 12'h0);
        // invalidate page, missing and matching
        issue_request(OP_FILL,   16'h1234, 32'h1234_5ABC, 32'hA5A5_A000, 12'hA5A);
        issue_request(OP_INV_PAGE, 16'h1234, 32'h1234_6000, 32'h0, 12'h0);
        issue_request(OP_LOOKUP, 16'h1234, 32'h1234_5FFF, 32'h0, 12'h0);
        issue_request(OP_INV_PAGE, 16'h1234, 32'h1234_5000, 32'h0, 12'h0);
        issue_request(OP_LOOKUP, 16'h1234, 32'h1234_5FFF, 32'h0, 12'h0);
        // invalidate one process, others stay
        issue_request(OP_FILL,   16'h1234, 32'h0000_1000, 32'h5A5A_5000, 12'h5A5);
        issue_request(OP_FILL,   16'h1234, 32'h0000_2000, 32'h0123_4000, 12'h123);
        issue_request(OP_FILL,   16'h0042, 32'h0000_3000, 32'h8000_0000, 12'h800);
        issue_request(OP_INV_PROC, 16'h1234, 32'h0, 32'h0, 12'h0);
        issue_request(OP_LOOKUP, 16'h1234, 32'h0000_1000, 32'h0, 12'h0);
        issue_request(OP_LOOKUP, 16'h1234, 32'h0000_2004, 32'h0, 12'h0);
        issue_request(OP_LOOKUP, 16'h0042, 32'h0000_3FFF, 32'h0, 12'h0);
        // flush, then unused opcodes
        issue_request(OP_FLUSH,  16'h0000, 32'h0, 32'h0, 12'h0);
        issue_request(OP_LOOKUP, 16'h0042, 32'h0000_3FFF, 32'h0, 12'h0);
        issue_request(OP_LOOKUP, 16'h0000, 32'h0000_0000, 32'h0, 12'h0);
        for (int op = OP_FLUSH + 1; op <= OPC_TOP; op++)
            issue_request(OPC_W'(op), PID_W'($urandom()), $urandom(), $urandom(),
                FLAG_W'($urandom()));
        wait_drained();

        // random traffic, one idling pattern per phase
        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:       begin send_idle = 0;  recv_stall = 0;  end
                1:       begin send_idle = 54; recv_stall = 0;  end
                2:       begin send_idle = 0;  recv_stall = 54; end
                default: begin send_idle = 37; recv_stall = 37; end
            endcase
            repeat (RANDOM_BEATS / PHASES)
            begin
                pick = $urandom_range(99);
                if (known_maps.size() != 0)
                    m = known_maps[$urandom_range(known_maps.size() - 1)];
                else
                begin
                    m.pid = busy_pids[$urandom_range(3)];
                    m.va  = $urandom();
                end
                if (pick < 34)
                begin
                    // lookup of a known mapping, any offset
                    va = {m.va[ADDR_W-1:PAGE_SHIFT], PAGE_SHIFT'($urandom())};
                    issue_request(OP_LOOKUP, m.pid, va, $urandom(), FLAG_W'($urandom()));
                end
                else if (pick < 54)
                begin
                    // new mapping, mostly for a few busy processes
                    pid = ($urandom_range(3) == 0) ? PID_W'($urandom())
                                                   : busy_pids[$urandom_range(3)];
                    va  = $urandom();
                    issue_request(OP_FILL, pid, va, $urandom(), FLAG_W'($urandom()));
                    m.pid = pid;
                    m.va  = va;
                    known_maps.push_back(m);
                    if (known_maps.size() > MAP_DEPTH)
                        known_maps.delete(0);
                end
                else if (pick < 61)
                begin
                    // refill a known mapping with a new frame
                    issue_request(OP_FILL, m.pid, m.va, $urandom(), FLAG_W'($urandom()));
                end
                else if (pick < 71)
                begin
                    // same slot, different tag
                    k = IDX_W'($urandom_range(1, ENTRIES - 1));
                    if ($urandom_range(1) == 0)
                    begin
                        pid = m.pid ^ PID_W'(k);
                        va  = m.va ^ (ADDR_W'(k) << PAGE_SHIFT);
                    end
                    else
                    begin
                        pid = m.pid;
                        va  = m.va ^ (ADDR_W'(k) << (PAGE_SHIFT + IDX_W));
                    end
                    issue_request(($urandom_range(3) == 0) ? OP_FILL : OP_LOOKUP, pid, va,
                        $urandom(), FLAG_W'($urandom()));
                end
                else if (pick < 77)
                begin
                    issue_request(OP_LOOKUP, PID_W'($urandom()), $urandom(), $urandom(),
                        FLAG_W'($urandom()));
                end
                else if (pick < 85)
                begin
                    // page invalidate, sometimes on a neighbor page
                    va = ($urandom_range(2) == 0) ? m.va + (ADDR_W'(1) << PAGE_SHIFT) : m.va;
                    issue_request(OP_INV_PAGE, m.pid, va, $urandom(), FLAG_W'($urandom()));
                end
                else if (pick < 88)
                begin
                    issue_request(OP_INV_PROC, busy_pids[$urandom_range(3)], $urandom(),
                        $urandom(), FLAG_W'($urandom()));
                end
                else if (pick < 90)
                begin
                    issue_request(OP_FLUSH, PID_W'($urandom()), $urandom(), $urandom(),
                        FLAG_W'($urandom()));
                    known_maps.delete();
                end
                else if (pick < 93)
                begin
                    issue_request(OPC_W'($urandom_range(OP_FLUSH + 1, OPC_TOP)),
                        PID_W'($urandom()), $urandom(), $urandom(), FLAG_W'($urandom()));
                end
                else
                begin
                    issue_request(OP_LOOKUP, busy_pids[$urandom_range(3)], $urandom(),
                        $urandom(), FLAG_W'($urandom()));
                end
            end
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fails == 0 && outstanding == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

### files.f
src/dmt_pkg.sv
src/dmt_ifs.sv
src/dmt_ram.sv
src/direct_mapped_tlb.sv
sim/translation_checker.sv
sim/testbench.sv
